@@ hw/rtl/madt_pkg.sv @@
// Shared types and constants for the MADT interrupt controller address parser.
// Holds the input/result item structs and the configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps

package madt_pkg;

  // Table layout
  localparam logic [31:0] HDR_END     = 32'd44;
  localparam logic [31:0] LOCAL_AT    = 32'd36;
  localparam logic [7:0]  MIN_ENTRY   = 8'd12;
  localparam logic [31:0] LOCAL_RESET = 32'hFEE0_0000;
  localparam logic [31:0] IO_RESET    = 32'hFEC0_0000;

  // Entry types of interest
  localparam logic [7:0] TYPE_IO_CTRL    = 8'd1;
  localparam logic [7:0] TYPE_LOCAL_OVRD = 8'd5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_DFLT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IO_DFLT    = 1'b1;

  typedef struct packed {
    logic [7:0] table_byte;
    logic       first_byte;
  } madt_in_t;

  typedef struct packed {
    logic [63:0] local_address;
    logic [31:0] io_address;
    logic        finished;
  } madt_out_t;

endpackage

@@ hw/rtl/madt_interrupt_controller_address_parser_unit.sv @@
// Top level of the MADT interrupt controller address parser.
// Parses table bytes in one pass and registers one result item per byte.
// Depends on madt_pkg.
//
// Usage:
//   in_*  : one table byte per item, in offset order; first_byte marks
//           offset 0 and restarts the parse.
//   out_* : one result item per input item: current local and I/O
//           controller addresses (configured default when the table gave
//           zero) and the finished flag.
//   cfg_* : write-only port for the two default address registers; write
//           only while no item is in flight.
// out_valid rises in the cycle after input accept. Throughput is one item
// per cycle unless out_stall holds a result; the parse state is updated by
// a single compare-and-shift pass per byte, so the state registers set it.
// The result register doubles as the skid stage: while it holds an item
// that out_stall blocks, in_stall is raised; otherwise a new item is taken
// every cycle even as the held item leaves.
// Reset (rst_n low, synchronous) clears the parse state, empties the result
// register and loads the default addresses 0xFEE00000 and 0xFEC00000.
// After the walk ends, bytes still produce results with unchanged values.
`timescale 1ns / 1ps

module madt_interrupt_controller_address_parser_unit
  import madt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  madt_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output madt_out_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Parse state
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] tlen_r, tlen_nxt;
  logic [31:0] es_r, es_nxt;
  logic [7:0]  etype_r, etype_nxt;
  logic [7:0]  elen_r, elen_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] local_r, local_nxt;
  logic [31:0] io_r, io_nxt;
  logic        done_r, done_nxt;

  // Configuration
  logic [31:0] local_dflt_r;
  logic [31:0] io_dflt_r;

  // Result register
  logic        out_valid_r;
  madt_out_t   out_data_r, out_data_nxt;

  logic        in_acc;
  logic [7:0]  b;

  // Walk helpers
  logic [32:0] diff;
  logic        rel_small;
  logic [7:0]  rel;
  logic [33:0] nx;
  logic [2:0]  fsh;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign b        = in_data.table_byte;

  // Position of the current byte relative to the current entry start
  always_comb begin
    diff      = {1'b0, (in_data.first_byte ? 32'd0 : offset_r)} -
                {1'b0, (in_data.first_byte ? HDR_END : es_r)};
    rel_small = !diff[32] && (diff[31:8] == 24'd0);
    rel       = diff[7:0];
  end

  // Next parse state for one accepted byte
  always_comb begin
    fsh = '0;
    nx  = '0;
    if (in_data.first_byte) begin
      offset_nxt = '0;
      tlen_nxt   = '0;
      es_nxt     = HDR_END;
      etype_nxt  = '0;
      elen_nxt   = '0;
      acc_nxt    = '0;
      local_nxt  = '0;
      io_nxt     = '0;
      done_nxt   = 1'b0;
    end else begin
      offset_nxt = offset_r;
      tlen_nxt   = tlen_r;
      es_nxt     = es_r;
      etype_nxt  = etype_r;
      elen_nxt   = elen_r;
      acc_nxt    = acc_r;
      local_nxt  = local_r;
      io_nxt     = io_r;
      done_nxt   = done_r;
    end

    if (!done_nxt) begin
      // Capture table length, bytes 4..7
      if (offset_nxt[31:2] == 30'd1) begin
        tlen_nxt = tlen_nxt | ({24'd0, b} << {offset_nxt[1:0], 3'b000});
      end
      // Capture header local address, bytes 36..39
      if (offset_nxt[31:2] == LOCAL_AT[31:2]) begin
        local_nxt = local_nxt | ({56'd0, b} << {offset_nxt[1:0], 3'b000});
      end

      if (offset_nxt == HDR_END - 32'd1) begin
        // Stop when no room for a first entry header
        if ({2'b00, HDR_END} + 34'd2 > {2'b00, tlen_nxt}) begin
          done_nxt = 1'b1;
        end
      end else if (offset_nxt >= HDR_END && rel_small) begin
        if (rel == 8'd0) begin
          // Type byte opens a new entry
          etype_nxt = b;
          acc_nxt   = '0;
        end else begin
          if (rel == 8'd1) begin
            // Length byte: stop on zero or overrun
            elen_nxt = b;
            if (b == 8'd0 || {2'b00, es_nxt} + {26'd0, b} > {2'b00, tlen_nxt}) begin
              done_nxt = 1'b1;
            end else if (b == 8'd1) begin
              // Length one: this byte is the next entry's type
              nx = {2'b00, es_nxt} + 34'd1;
              if (nx + 34'd2 > {2'b00, tlen_nxt}) begin
                done_nxt = 1'b1;
              end else begin
                es_nxt    = nx[31:0];
                etype_nxt = b;
                elen_nxt  = '0;
                acc_nxt   = '0;
              end
            end
          end else if (rel >= 8'd4 && rel < 8'd12) begin
            // Gather the field at +4
            fsh     = 3'(rel - 8'd4);
            acc_nxt = acc_nxt | ({56'd0, b} << {fsh, 3'b000});
            if (elen_nxt >= MIN_ENTRY) begin
              if (etype_nxt == TYPE_IO_CTRL && rel == 8'd7) begin
                io_nxt = acc_nxt[31:0];
              end else if (etype_nxt == TYPE_LOCAL_OVRD && rel == 8'd11) begin
                local_nxt = acc_nxt;
              end
            end
          end
          // Last byte of an entry: advance or stop
          if (!done_nxt && !(rel == 8'd1 && b == 8'd1) &&
              elen_nxt >= 8'd2 && rel == elen_nxt - 8'd1) begin
            nx = {2'b00, es_nxt} + {26'd0, elen_nxt};
            if (nx + 34'd2 > {2'b00, tlen_nxt}) begin
              done_nxt = 1'b1;
            end else begin
              es_nxt   = nx[31:0];
              elen_nxt = '0;
            end
          end
        end
      end

      // Advance offset, saturating
      if (!done_nxt && offset_nxt != 32'hFFFF_FFFF) begin
        offset_nxt = offset_nxt + 32'd1;
      end
    end
  end

  // Result fields with defaults substituted
  always_comb begin
    out_data_nxt.local_address = (local_nxt != 64'd0) ? local_nxt : {32'd0, local_dflt_r};
    out_data_nxt.io_address    = (io_nxt != 32'd0) ? io_nxt : io_dflt_r;
    out_data_nxt.finished      = done_nxt;
  end

  // Hold parse state, configuration and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r     <= '0;
      tlen_r       <= '0;
      es_r         <= HDR_END;
      etype_r      <= '0;
      elen_r       <= '0;
      acc_r        <= '0;
      local_r      <= '0;
      io_r         <= '0;
      done_r       <= 1'b0;
      local_dflt_r <= LOCAL_RESET;
      io_dflt_r    <= IO_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        offset_r <= offset_nxt;
        tlen_r   <= tlen_nxt;
        es_r     <= es_nxt;
        etype_r  <= etype_nxt;
        elen_r   <= elen_nxt;
        acc_r    <= acc_nxt;
        local_r  <= local_nxt;
        io_r     <= io_nxt;
        done_r   <= done_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LOCAL_DFLT: local_dflt_r <= cfg_wdata;
          REG_IO_DFLT:    io_dflt_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Load result payload on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Every accepted item shows up as a result next cycle
  a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item produced no result");

  // Entry start stays at the header end until the walk begins
  a_es_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    (offset_r < HDR_END) |-> (es_r == HDR_END))
    else $error("entry start moved inside the header");

  // After finish, bytes without restart change nothing
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && in_acc && !in_data.first_byte) |=>
      (done_r && $stable(offset_r) && $stable(local_r) && $stable(io_r)))
    else $error("parse state changed after finish");

  // Result finished flag tracks the parse state
  a_finished_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_data_r.finished == done_r))
    else $error("finished flag disagrees with walk state");
`endif

endmodule
